// ----- src/fsde_pkg.sv -----
// ----------------------------------------------------------------------------
// fsde_pkg
// shared types, constants and tables of the fourier series derivative unit
// ----------------------------------------------------------------------------
package fsde_pkg;

  localparam int MAX_HARMONICS_DEF = 64;
  localparam int CORDIC_STEPS_DEF  = 24;

  // cordic datapath width and multiplier operand widths
  localparam int CS_W = 34;
  localparam int MA_W = 64;
  localparam int MB_W = 48;
  localparam int MD_W = 24;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_PHASE = 2'd1;
  localparam logic [1:0] REG_WAVE  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [5:0]         harmonic_index;
    logic signed [31:0] cos_coef;
    logic signed [31:0] sin_coef;
    logic [15:0]        grid_index;
  } req_t;

  typedef struct packed {
    logic signed [63:0] first_deriv;
    logic signed [63:0] second_deriv;
    logic signed [63:0] third_deriv;
    logic               overflow;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_FETCH,
    ST_CORDIC,
    ST_PROD,
    ST_TERMS,
    ST_SCALE
  } state_t;

  // arctangent of 2^-i in q0.32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/fsde_mul.sv -----
// ----------------------------------------------------------------------------
// fsde_mul
// unsigned multiplier, 64 by 48 bits, one 32 by 24 bit partial product a cycle
// ----------------------------------------------------------------------------
module fsde_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fsde_pkg::MA_W-1:0] a,
  input  logic [fsde_pkg::MB_W-1:0] b,
  output logic                      done,
  output logic [fsde_pkg::MP_W-1:0] prod
);
  import fsde_pkg::*;

  localparam int MH_W = MA_W / 2;

  logic [MA_W-1:0]      a_reg;
  logic [MB_W-1:0]      b_reg;
  logic                 busy;
  logic [1:0]           cnt;
  logic [MH_W-1:0]      a_half;
  logic [MD_W-1:0]      digit;
  logic [MH_W+MD_W-1:0] part;
  logic [MP_W-1:0]      part_sh;

  // half of a selected by cnt[0], digit of b by cnt[1]
  assign a_half = cnt[0] ? a_reg[MA_W-1:MH_W] : a_reg[MH_W-1:0];
  assign digit  = cnt[1] ? b_reg[MB_W-1:MD_W] : b_reg[MD_W-1:0];
  assign part   = a_half * digit;

  always_comb begin
    case (cnt)
      2'd0:    part_sh = MP_W'(part);
      2'd1:    part_sh = MP_W'(part) << MH_W;
      2'd2:    part_sh = MP_W'(part) << MD_W;
      default: part_sh = MP_W'(part) << (MH_W + MD_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
    end else if (busy) begin
      prod <= prod + part_sh;
    end
  end

endmodule

// ----- src/fsde_cordic.sv -----
// ----------------------------------------------------------------------------
// fsde_cordic
// rotation mode cordic, one step per cycle, phase in q0.32 turns
// ----------------------------------------------------------------------------
module fsde_cordic #(
  parameter int STEPS = fsde_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [31:0]                      phase,
  output logic                             done,
  output logic signed [fsde_pkg::CS_W-1:0] cos_val,
  output logic signed [fsde_pkg::CS_W-1:0] sin_val
);
  import fsde_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic                   busy;
  logic [IW-1:0]          i;
  logic [1:0]             q;
  logic signed [CS_W-1:0] x;
  logic signed [CS_W-1:0] y;
  logic signed [CS_W-1:0] z;
  logic signed [CS_W-1:0] dx;
  logic signed [CS_W-1:0] dy;
  logic signed [CS_W-1:0] at;
  logic [31:0]            qs;
  logic [31:0]            rr;

  assign qs = phase + 32'h20000000;
  assign rr = phase - {qs[31:30], 30'b0};
  assign dx = y >>> i;
  assign dy = x >>> i;
  assign at = signed'({{(CS_W-32){1'b0}}, atan_turns(5'(i))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        if (i == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        i <= i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= qs[31:30];
      x <= signed'(CS_W'(CORDIC_X0));
      y <= '0;
      z <= signed'({{(CS_W-32){rr[31]}}, rr});
    end else if (busy) begin
      if (!z[CS_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  // quadrant rotation
  always_comb begin
    case (q)
      2'd0: begin
        cos_val = x;
        sin_val = y;
      end
      2'd1: begin
        cos_val = -y;
        sin_val = x;
      end
      2'd2: begin
        cos_val = -x;
        sin_val = -y;
      end
      default: begin
        cos_val = y;
        sin_val = -x;
      end
    endcase
  end

endmodule

// ----- src/fourier_series_derivative_eval.sv -----
// ----------------------------------------------------------------------------
// fourier_series_derivative_eval
// sums first, second and third derivatives of a stored fourier series
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// writes the cosine/sine pair of one harmonic in a single cycle and gives no
// result; busy stays low, so loads may follow every cycle. An evaluate
// request raises busy and later gives one result on rsp, marked by rsp_valid
// for exactly one cycle; the receiver cannot stall it, and a new request can
// be taken in that same cycle.
// An evaluate sums the harmonics 1 to count-1, count being harmonic_count
// limited to MAX_HARMONICS. Per harmonic the cordic runs one step a cycle,
// and ten products go through the one shared 32x24 multiplier. A count of 0
// or 1 answers in the cycle after it is taken, with zero sums.
// The user writes registers over the apb port only while the block is idle;
// the block does not enforce it. Reset clears the registers and the
// sequencer; the coefficient store is undefined until loaded.
// ----------------------------------------------------------------------------
module fourier_series_derivative_eval #(
  parameter int MAX_HARMONICS = fsde_pkg::MAX_HARMONICS_DEF,
  parameter int CORDIC_STEPS  = fsde_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  fsde_pkg::req_t req,
  output logic           rsp_valid,
  output fsde_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fsde_pkg::*;

  localparam int IDX_W = $clog2(MAX_HARMONICS);
  localparam int CNT_W = $clog2(MAX_HARMONICS + 1);
  localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int KN_W  = 32 + CNT_W;
  localparam int PR_W  = 66;
  localparam int SM_W  = 68;
  localparam logic [63:0] S64_MAX = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] S64_MIN = 64'h8000000000000000;

  // configuration
  logic [6:0]  harmonic_count;
  logic [31:0] phase_step;
  logic [31:0] wave_number_base;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_count   <= '0;
      phase_step       <= '0;
      wave_number_base <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COUNT: harmonic_count   <= pwdata[6:0];
        REG_PHASE: phase_step       <= pwdata;
        REG_WAVE:  wave_number_base <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COUNT: prdata = {25'b0, harmonic_count};
      REG_PHASE: prdata = phase_step;
      REG_WAVE:  prdata = wave_number_base;
      default:   prdata = '0;
    endcase
  end

  // sequencer state
  state_t                 state;
  state_t                 state_next;
  logic                   launched;
  logic [2:0]             step;
  logic                   accept;
  logic                   mul_start;
  logic                   cordic_start;
  logic [LIM_W-1:0]       lim;
  logic [LIM_W-1:0]       n_plus;
  logic                   more;

  // datapath
  logic [CNT_W-1:0]       n;
  logic [15:0]            grid;
  logic [31:0]            base;
  logic [31:0]            ph;
  logic [KN_W-1:0]        kn;
  logic [63:0]            coef_mem [MAX_HARMONICS];
  logic [63:0]            coef_rd;
  logic signed [31:0]     coef_a;
  logic signed [31:0]     coef_b;
  logic signed [CS_W-1:0] c_val;
  logic signed [CS_W-1:0] s_val;
  logic signed [CS_W-1:0] cordic_cos;
  logic signed [CS_W-1:0] cordic_sin;
  logic                   cordic_done;
  logic signed [PR_W-1:0] p_as;
  logic signed [PR_W-1:0] p_bc;
  logic signed [PR_W-1:0] p_ac;
  logic signed [PR_W-1:0] p_bs;
  logic signed [SM_W-1:0] sum_x;
  logic signed [SM_W-1:0] sum_nx;
  logic signed [SM_W-1:0] sum_y;
  logic signed [63:0]     t1;
  logic signed [63:0]     t2;
  logic signed [63:0]     t3;
  logic signed [63:0]     u;
  logic signed [63:0]     f;
  logic signed [63:0]     s2;
  logic signed [63:0]     s3;
  logic                   ovf;

  // shared multiplier operands and result handling
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [MP_W-1:0]        mul_prod;
  logic                   mul_done;
  logic signed [31:0]     op1;
  logic signed [CS_W-1:0] op2;
  logic [63:0]            op1_ext;
  logic [CS_W-1:0]        op2_mag;
  logic                   prod_neg;
  logic signed [PR_W-1:0] prod_s;
  logic signed [63:0]     sv;
  logic                   sv_neg;
  logic                   sh40;
  logic [MP_W-1:0]        q_pos;
  logic [MP_W-1:0]        q_neg;
  logic                   rem_nz;
  logic [63:0]            r;
  logic                   r_ovf;
  logic signed [63:0]     acc;
  logic signed [64:0]     acc_sum;
  logic [63:0]            acc_new;
  logic                   add_ovf;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign lim    = (LIM_W'(harmonic_count) > LIM_W'(MAX_HARMONICS)) ?
                  LIM_W'(MAX_HARMONICS) : LIM_W'(harmonic_count);
  assign n_plus = LIM_W'(n) + 1'b1;
  assign more   = (n_plus < lim);
  assign coef_a = coef_rd[63:32];
  assign coef_b = coef_rd[31:0];

  // coefficient store
  always_ff @(posedge clk) begin
    if (accept && req.operation == OP_LOAD &&
        32'(req.harmonic_index) < 32'(MAX_HARMONICS)) begin
      coef_mem[IDX_W'(req.harmonic_index)] <= {req.cos_coef, req.sin_coef};
    end
    coef_rd <= coef_mem[n[IDX_W-1:0]];
  end

  // operand select
  always_comb begin
    op1      = step[0] ? coef_b : coef_a;
    op2      = (step[0] ^ step[1]) ? c_val : s_val;
    op1_ext  = 64'(op1);
    op2_mag  = op2[CS_W-1] ? CS_W'(-op2) : CS_W'(op2);
    prod_neg = op1[31] ^ op2[CS_W-1];
    case (step)
      3'd0:    sv = t1;
      3'd1:    sv = t2;
      3'd3:    sv = t3;
      default: sv = u;
    endcase
    sv_neg = sv[63];
    case (state)
      ST_BASE: begin
        mul_a = MA_W'(phase_step);
        mul_b = MB_W'(grid);
      end
      ST_PROD: begin
        mul_a = op1[31] ? MA_W'(-op1_ext) : MA_W'(op1_ext);
        mul_b = MB_W'(op2_mag);
      end
      ST_SCALE: begin
        mul_a = sv_neg ? MA_W'(-sv) : MA_W'(sv);
        mul_b = MB_W'(kn);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // signed product, scaling with floor and saturation, saturating add
  always_comb begin
    prod_s = prod_neg ? -signed'(PR_W'(mul_prod)) : signed'(PR_W'(mul_prod));
    sh40   = (step == 3'd0) || (step == 3'd2) || (step == 3'd5);
    q_pos  = sh40 ? (mul_prod >> 40) : (mul_prod >> 20);
    rem_nz = sh40 ? (|mul_prod[39:0]) : (|mul_prod[19:0]);
    q_neg  = q_pos + MP_W'(rem_nz);
    if (sv_neg) begin
      if (q_neg > MP_W'(S64_MIN)) begin
        r     = S64_MIN;
        r_ovf = 1'b1;
      end else begin
        r     = -q_neg[63:0];
        r_ovf = 1'b0;
      end
    end else begin
      if (q_pos > MP_W'(S64_MAX)) begin
        r     = S64_MAX;
        r_ovf = 1'b1;
      end else begin
        r     = q_pos[63:0];
        r_ovf = 1'b0;
      end
    end
    case (step)
      3'd0:    acc = f;
      3'd2:    acc = s2;
      default: acc = s3;
    endcase
    acc_sum = {acc[63], acc} + {r[63], r};
    if (acc_sum[64] != acc_sum[63]) begin
      add_ovf = 1'b1;
      acc_new = acc_sum[64] ? S64_MIN : S64_MAX;
    end else begin
      add_ovf = 1'b0;
      acc_new = acc_sum[63:0];
    end
  end

  assign sum_x  = p_as + p_bc;
  assign sum_nx = -sum_x;
  assign sum_y  = p_bs - p_ac;

  // next state and unit launches
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    cordic_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && req.operation == OP_EVAL && lim > LIM_W'(1)) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        mul_start = !launched;
        if (mul_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        cordic_start = !launched;
        if (cordic_done) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        mul_start = !launched;
        if (mul_done && step == 3'd3) begin
          state_next = ST_TERMS;
        end
      end
      ST_TERMS: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        mul_start = !launched;
        if (mul_done && step == 3'd5) begin
          state_next = more ? ST_FETCH : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launched  <= 1'b0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= 1'b0;
      if (mul_start || cordic_start) begin
        launched <= 1'b1;
      end else if (mul_done || cordic_done) begin
        launched <= 1'b0;
      end
      if (state == ST_FETCH || state == ST_TERMS) begin
        step <= '0;
      end else if (mul_done && (state == ST_PROD || state == ST_SCALE)) begin
        step <= step + 1'b1;
      end
      if (accept && req.operation == OP_EVAL && lim <= LIM_W'(1)) begin
        rsp_valid <= 1'b1;
      end
      if (state == ST_SCALE && mul_done && step == 3'd5 && !more) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && req.operation == OP_EVAL) begin
          grid <= req.grid_index;
          f    <= '0;
          s2   <= '0;
          s3   <= '0;
          ovf  <= 1'b0;
          rsp  <= '0;
        end
      end
      ST_BASE: begin
        if (mul_done) begin
          base <= mul_prod[31:0] + 32'h80000000;
          ph   <= mul_prod[31:0] + 32'h80000000;
          kn   <= KN_W'(wave_number_base);
          n    <= CNT_W'(1);
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          c_val <= cordic_cos;
          s_val <= cordic_sin;
        end
      end
      ST_PROD: begin
        if (mul_done) begin
          case (step[1:0])
            2'd0:    p_as <= prod_s;
            2'd1:    p_bc <= prod_s;
            2'd2:    p_ac <= prod_s;
            default: p_bs <= prod_s;
          endcase
        end
      end
      ST_TERMS: begin
        t1 <= 64'(sum_nx >>> 19);
        t2 <= 64'(sum_y >>> 19);
        t3 <= 64'(sum_x >>> 19);
      end
      ST_SCALE: begin
        if (mul_done) begin
          ovf <= ovf | r_ovf |
                 (add_ovf && (step == 3'd0 || step == 3'd2 || step == 3'd5));
          case (step)
            3'd0: f  <= acc_new;
            3'd2: s2 <= acc_new;
            3'd5: s3 <= acc_new;
            default: u <= r;
          endcase
          if (step == 3'd5) begin
            if (more) begin
              n  <= n + 1'b1;
              ph <= ph + base;
              kn <= kn + KN_W'(wave_number_base);
            end else begin
              rsp.first_deriv  <= f;
              rsp.second_deriv <= s2;
              rsp.third_deriv  <= acc_new;
              rsp.overflow     <= ovf | r_ovf | add_ovf;
            end
          end
        end
      end
      default: ;
    endcase
  end

  fsde_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  fsde_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .phase   (ph),
    .done    (cordic_done),
    .cos_val (cordic_cos),
    .sin_val (cordic_sin)
  );

`ifndef SYNTHESIS
  a_rsp_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> state == ST_IDLE)
    else $error("result strobe while sequencer busy");

  a_short_eval: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_EVAL && lim <= LIM_W'(1)) |=> rsp_valid)
    else $error("short evaluate gave no result");

  a_n_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORDIC) |-> (n != '0 && LIM_W'(n) < lim))
    else $error("harmonic index out of range");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROD) |-> step < 3'd4)
    else $error("product step out of range");
`endif

endmodule
